// ===== design/mdiofm_pkg.sv =====
// Package for the MDIO management frame master.
// Holds the frame timing constants, the action codes and the item and result types.
// No dependencies; every design file refers to it by scoped names.
package mdiofm_pkg;

    localparam int PREAMBLE_BITS = 32;
    localparam int POS_W         = 7;

    localparam logic [POS_W-1:0] POS_HDR_START  = POS_W'(PREAMBLE_BITS);
    localparam logic [POS_W-1:0] POS_TA_START   = POS_W'(PREAMBLE_BITS + 14);
    localparam logic [POS_W-1:0] POS_DATA_START = POS_W'(PREAMBLE_BITS + 16);
    localparam logic [POS_W-1:0] POS_IDLE       = POS_W'(PREAMBLE_BITS + 32);

    localparam logic [1:0] START_BITS = 2'b01;
    localparam logic [1:0] OP_READ    = 2'b10;
    localparam logic [1:0] OP_WRITE   = 2'b01;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [4:0]  reg_address;
        logic [15:0] write_data;
        logic        mdi_in;
    } item_t;

    typedef struct packed {
        logic        mdo;
        logic        mdo_enable;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
        logic        request_ignored;
    } result_t;

endpackage

// ===== design/mdiofm_frame_engine.sv =====
// Frame sequencer of the MDIO management frame master: holds the frame state and
// turns one bit-time transaction into one result in a single pass.
// Depends on mdiofm_pkg.
module mdiofm_frame_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  mdiofm_pkg::item_t item,
    input  logic [4:0]        phy_address,
    output mdiofm_pkg::result_t result
);

    logic [mdiofm_pkg::POS_W-1:0] bit_position_reg, bit_position_next;
    logic                         frame_active_reg, frame_active_next;
    logic                         is_read_reg, is_read_next;
    logic [13:0]                  frame_header_reg, frame_header_next;
    logic [15:0]                  out_shift_reg, out_shift_next;
    logic [15:0]                  in_shift_reg, in_shift_next;

    logic                         request;
    logic                         start;
    logic [mdiofm_pkg::POS_W-1:0] pos;
    logic                         rd;
    logic [13:0]                  header;
    logic [15:0]                  oshift;
    logic                         done;

    always_comb begin
        request = (item.action == mdiofm_pkg::ACT_READ) ||
                  (item.action == mdiofm_pkg::ACT_WRITE);
        start   = request && !frame_active_reg;
        pos     = start ? '0 : bit_position_reg;
        rd      = start ? (item.action == mdiofm_pkg::ACT_READ) : is_read_reg;
        header  = start ? {mdiofm_pkg::START_BITS,
                           (item.action == mdiofm_pkg::ACT_READ) ?
                               mdiofm_pkg::OP_READ : mdiofm_pkg::OP_WRITE,
                           phy_address, item.reg_address}
                        : frame_header_reg;
        oshift  = start ? ((item.action == mdiofm_pkg::ACT_READ) ? 16'h0000 : item.write_data)
                        : out_shift_reg;

        bit_position_next = bit_position_reg;
        frame_active_next = frame_active_reg || start;
        is_read_next      = rd;
        frame_header_next = header;
        out_shift_next    = oshift;
        in_shift_next     = in_shift_reg;
        done              = 1'b0;

        result.mdo             = 1'b0;
        result.mdo_enable      = 1'b0;
        result.busy_res        = 1'b0;
        result.done_res        = 1'b0;
        result.request_ignored = request && frame_active_reg;

        if (frame_active_reg || start) begin
            result.busy_res = 1'b1;
            if (pos < mdiofm_pkg::POS_HDR_START) begin
                result.mdo        = 1'b1;
                result.mdo_enable = 1'b1;
            end else if (pos < mdiofm_pkg::POS_TA_START) begin
                result.mdo        = header[13];
                result.mdo_enable = 1'b1;
                frame_header_next = {header[12:0], 1'b0};
            end else if (pos < mdiofm_pkg::POS_DATA_START) begin
                result.mdo_enable = 1'b0;
            end else if (pos < mdiofm_pkg::POS_IDLE) begin
                if (rd) begin
                    in_shift_next = {in_shift_reg[14:0], item.mdi_in};
                end else begin
                    result.mdo        = oshift[15];
                    result.mdo_enable = 1'b1;
                    out_shift_next    = {oshift[14:0], 1'b0};
                end
            end else begin
                done = 1'b1;
            end
            if (done) begin
                frame_active_next = 1'b0;
                bit_position_next = '0;
            end else begin
                bit_position_next = pos + 1'b1;
            end
        end
        result.done_res  = done;
        result.read_data = in_shift_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_position_reg <= '0;
            frame_active_reg <= 1'b0;
            is_read_reg      <= 1'b0;
            frame_header_reg <= '0;
            out_shift_reg    <= '0;
            in_shift_reg     <= '0;
        end else if (step_en) begin
            bit_position_reg <= bit_position_next;
            frame_active_reg <= frame_active_next;
            is_read_reg      <= is_read_next;
            frame_header_reg <= frame_header_next;
            out_shift_reg    <= out_shift_next;
            in_shift_reg     <= in_shift_next;
        end
    end

endmodule

// ===== design/mdio_management_frame_master_core.sv =====
// Top level of the MDIO management frame master: input register, frame engine,
// result register and the PHY address register.
// Depends on mdiofm_pkg and mdiofm_frame_engine.
//
//   Channel   Ports                         Payload
//   input     s_tvalid/s_tready/s_tdata/    one bit time: action, register address,
//             s_tuser                       write data, sampled MDI level
//   result    m_tvalid/m_tready/m_tdata/    MDO level and enable, busy, read data,
//             m_tlast                       ignored flag; m_tlast marks frame end
//   config    cfg_we/cfg_wdata              PHY address
//
// One transaction per cycle is sustained while the result side takes every result; a result
// passes through the input register and the result register before it is presented.
// The frame engine state advances once per transaction in a single pass.
// A stall on the result side holds both registers and lowers s_tready.
// Reset is synchronous and clears the frame state and the PHY address.
module mdio_management_frame_master_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // reg_address[4:0], write_data[20:5], mdi_in[21], zero
    input  logic [1:0]  s_tuser,  // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // mdo[0], mdo_enable[1], busy_res[2], read_data[18:3],
                                  // request_ignored[19], zero
    output logic        m_tlast   // done_res
);

    logic [4:0]          phy_address_reg;
    logic                in_valid_reg;
    mdiofm_pkg::item_t   in_item_reg;
    logic                out_valid_reg;
    mdiofm_pkg::result_t out_result_reg;
    mdiofm_pkg::result_t result;
    logic                advance;
    logic                s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phy_address_reg <= '0;
        end else if (cfg_we) begin
            phy_address_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.action      <= mdiofm_pkg::action_t'(s_tuser);
            in_item_reg.reg_address <= s_tdata[4:0];
            in_item_reg.write_data  <= s_tdata[20:5];
            in_item_reg.mdi_in      <= s_tdata[21];
        end
    end

    mdiofm_frame_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .item        (in_item_reg),
        .phy_address (phy_address_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_result_reg.done_res;
    assign m_tdata  = {4'b0000,
                       out_result_reg.request_ignored,
                       out_result_reg.read_data,
                       out_result_reg.busy_res,
                       out_result_reg.mdo_enable,
                       out_result_reg.mdo};

endmodule

// ===== test/mdio_frame_checker.sv =====
// Checker for the MDIO management frame master: watches the configuration port and
// both stream channels, predicts each bit time's result and compares it field by field.
// Depends on mdiofm_pkg for the action codes, frame constants and item/result types.
module mdio_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding,
    output int          reads_started,
    output int          writes_started,
    output int          starts_ignored,
    output int          results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [4:0]          phy_addr;
    logic [6:0]          frame_pos;
    logic                in_frame;
    logic                read_frame;
    logic [13:0]         header_bits;
    logic [15:0]         write_bits;
    logic [15:0]         read_bits;
    mdiofm_pkg::result_t bit_time_q[$];

    initial begin
        mismatches      = 0;
        outstanding     = 0;
        reads_started   = 0;
        writes_started  = 0;
        starts_ignored  = 0;
        results_checked = 0;
    end

    function automatic mdiofm_pkg::result_t next_bit_time(mdiofm_pkg::item_t it);
        mdiofm_pkg::result_t r;
        logic                request;
        r = '0;
        request = (it.action == mdiofm_pkg::ACT_READ) || (it.action == mdiofm_pkg::ACT_WRITE);
        if (request && in_frame) begin
            r.request_ignored = 1'b1;
            starts_ignored++;
        end else if (request) begin
            in_frame    = 1'b1;
            read_frame  = (it.action == mdiofm_pkg::ACT_READ);
            frame_pos   = '0;
            header_bits = {mdiofm_pkg::START_BITS,
                           read_frame ? mdiofm_pkg::OP_READ : mdiofm_pkg::OP_WRITE,
                           phy_addr, it.reg_address};
            write_bits  = read_frame ? 16'h0000 : it.write_data;
            if (read_frame) reads_started++;
            else writes_started++;
        end
        if (in_frame) begin
            r.busy_res = 1'b1;
            if (frame_pos < mdiofm_pkg::PREAMBLE_BITS) begin
                r.mdo        = 1'b1;
                r.mdo_enable = 1'b1;
            end else if (frame_pos < mdiofm_pkg::PREAMBLE_BITS + 14) begin
                r.mdo        = header_bits[13];
                r.mdo_enable = 1'b1;
                header_bits  = header_bits << 1;
            end else if (frame_pos < mdiofm_pkg::PREAMBLE_BITS + 16) begin
                // Turnaround: the line is released.
            end else if (frame_pos < mdiofm_pkg::PREAMBLE_BITS + 32) begin
                if (read_frame) begin
                    read_bits = {read_bits[14:0], it.mdi_in};
                end else begin
                    r.mdo        = write_bits[15];
                    r.mdo_enable = 1'b1;
                    write_bits   = write_bits << 1;
                end
            end else begin
                r.done_res = 1'b1;
            end
            if (r.done_res) begin
                in_frame  = 1'b0;
                frame_pos = '0;
            end else begin
                frame_pos = frame_pos + 7'd1;
            end
        end
        r.read_data = read_bits;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        mdiofm_pkg::result_t want;
        mdiofm_pkg::item_t   it;
        if (!aresetn) begin
            phy_addr    = '0;
            frame_pos   = '0;
            in_frame    = 1'b0;
            read_frame  = 1'b0;
            header_bits = '0;
            write_bits  = '0;
            read_bits   = '0;
            bit_time_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (bit_time_q.size() == 0) begin
                    $error("result transaction with no bit time pending: tdata 0x%0h",
                           m_tdata);
                    mismatches++;
                end else begin
                    want = bit_time_q.pop_front();
                    check_field("mdo", want.mdo, m_tdata[0]);
                    check_field("mdo_enable", want.mdo_enable, m_tdata[1]);
                    check_field("busy_res", want.busy_res, m_tdata[2]);
                    check_field("done_res", want.done_res, m_tlast);
                    check_field("read_data", want.read_data, m_tdata[18:3]);
                    check_field("request_ignored", want.request_ignored, m_tdata[19]);
                    results_checked++;
                end
            end
            if (cfg_we) phy_addr = cfg_wdata;
            if (s_tvalid && s_tready) begin
                it.action      = mdiofm_pkg::action_t'(s_tuser);
                it.reg_address = s_tdata[4:0];
                it.write_data  = s_tdata[20:5];
                it.mdi_in      = s_tdata[21];
                bit_time_q.push_back(next_bit_time(it));
            end
        end
        outstanding = bit_time_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the MDIO management frame master testbench: clock, reset, configuration
// writes, bursty bit-time stimulus and a stalling result receiver; gives the verdict.
// Depends on mdiofm_pkg, mdio_management_frame_master_core and mdio_frame_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_BITS  = mdiofm_pkg::PREAMBLE_BITS + 33;
    localparam int CYCLE_LIMIT = 300000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;
    logic        m_tlast;

    int mismatches, outstanding, reads_started, writes_started;
    int starts_ignored, results_checked;
    int cycles = 0;
    int items_sent = 0;
    int burst_left = 0;
    int frame_left = 0;

    mdio_management_frame_master_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    mdio_frame_checker frame_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .mismatches(mismatches), .outstanding(outstanding),
        .reads_started(reads_started), .writes_started(writes_started),
        .starts_ignored(starts_ignored), .results_checked(results_checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("mdio_management_frame_master_core regression: fail");
            $finish;
        end
    end

    // Receiver stall pattern: the mode is redrawn at random from four patterns.
    int rx_mode = 0;
    int rx_count = 0;
    always @(negedge aclk) begin
        rx_count <= rx_count + 1;
        if (rx_count % 150 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= (rx_count % 7 > 1);
            default: m_tready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    task automatic send(mdiofm_pkg::action_t act, logic [4:0] ra, logic [15:0] wd,
                        logic mdi);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, mdi, wd, ra};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (frame_left > 0) frame_left--;
        else if (act == mdiofm_pkg::ACT_READ || act == mdiofm_pkg::ACT_WRITE)
            frame_left = FRAME_BITS - 1;
    endtask

    task automatic tick(logic mdi);
        send(mdiofm_pkg::ACT_TICK, 5'($urandom), 16'($urandom), mdi);
    endtask

    // One frame: its start, then every remaining bit time, with an optional extra
    // action on one bit time and the MDI level either fixed or random.
    task automatic play_frame(mdiofm_pkg::action_t act, logic [4:0] ra, logic [15:0] wd,
                              int poke_pos, mdiofm_pkg::action_t poke_act,
                              bit mdi_random, logic mdi_level);
        logic mdi;
        for (int k = 0; k < FRAME_BITS; k++) begin
            mdi = mdi_random ? 1'($urandom) : mdi_level;
            if (k == 0) send(act, ra, wd, mdi);
            else if (k == poke_pos) send(poke_act, 5'($urandom), 16'($urandom), mdi);
            else tick(mdi);
        end
    endtask

    task automatic set_phy(logic [4:0] addr);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        mdiofm_pkg::action_t act;
        int                  phase_start;
        logic [4:0]          phase_phy[5];
        phase_phy = '{5'd31, 5'd0, 5'($urandom), 5'h15, 5'h0A};

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part.
        set_phy(5'd31);
        send(mdiofm_pkg::ACT_NONE, 5'd31, 16'hFFFF, 1'b1);
        tick(1'b0);
        play_frame(mdiofm_pkg::ACT_WRITE, 5'd31, 16'hFFFF, 0, mdiofm_pkg::ACT_TICK,
                   1'b0, 1'b1);
        play_frame(mdiofm_pkg::ACT_READ, 5'd0, 16'hFFFF, 5, mdiofm_pkg::ACT_WRITE,
                   1'b0, 1'b1);
        play_frame(mdiofm_pkg::ACT_READ, 5'h15, 16'h0000, FRAME_BITS - 1,
                   mdiofm_pkg::ACT_READ, 1'b0, 1'b0);
        play_frame(mdiofm_pkg::ACT_WRITE, 5'd0, 16'h0000, 40, mdiofm_pkg::ACT_NONE,
                   1'b0, 1'b1);
        set_phy(5'd0);
        play_frame(mdiofm_pkg::ACT_WRITE, 5'h0A, 16'hA5A5, 20, mdiofm_pkg::ACT_READ,
                   1'b1, 1'b0);
        play_frame(mdiofm_pkg::ACT_READ, 5'h1F, 16'h5A5A, 55, mdiofm_pkg::ACT_WRITE,
                   1'b1, 1'b0);
        tick(1'b1);

        // Random part: mostly whole frames, some unstructured noise.
        foreach (phase_phy[p]) begin
            set_phy(phase_phy[p]);
            phase_start = items_sent;
            while (items_sent - phase_start < 150) begin
                if ($urandom_range(0, 4) != 0) begin
                    while (frame_left > 0) tick(1'($urandom));
                    act = ($urandom_range(0, 1) == 1) ? mdiofm_pkg::ACT_READ
                                                      : mdiofm_pkg::ACT_WRITE;
                    play_frame(act, 5'($urandom), 16'($urandom),
                               ($urandom_range(0, 2) == 0) ? $urandom_range(1, FRAME_BITS - 1)
                                                           : 0,
                               mdiofm_pkg::action_t'($urandom_range(1, 3)), 1'b1, 1'b0);
                    repeat ($urandom_range(0, 2)) tick(1'($urandom));
                end else begin
                    repeat ($urandom_range(10, 40))
                        send(mdiofm_pkg::action_t'($urandom_range(0, 3)), 5'($urandom),
                             16'($urandom), 1'($urandom));
                end
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);

        $display("Covered %0d bit times: %0d read and %0d write frames, %0d ignored starts.",
                 results_checked, reads_started, writes_started, starts_ignored);
        $display("PHY addresses 31, 0, 21, 10 and one random value were used.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("mdio_management_frame_master_core regression: pass");
        end else begin
            $display("mdio_management_frame_master_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mdiofm_pkg.sv
design/mdiofm_frame_engine.sv
design/mdio_management_frame_master_core.sv
test/mdio_frame_checker.sv
test/tb_top.sv
